FILE: rtl/core/duty_cycle_suspend_scheduler_unit_macros.svh
// Assertion macros shared by the checker
`ifndef DUTY_CYCLE_SUSPEND_SCHEDULER_UNIT_MACROS_SVH
`define DUTY_CYCLE_SUSPEND_SCHEDULER_UNIT_MACROS_SVH
// implication checked every clock edge outside reset
`define DCSS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define DCSS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/core/dcss_pkg.sv
`default_nettype none
package dcss_pkg;
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_EXIT = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [2:0] EV_RESUME  = 3'd0;
  localparam logic [2:0] EV_SUSPEND = 3'd1;
  localparam logic [2:0] EV_DROP    = 3'd2;
  localparam logic [2:0] EV_WAKE    = 3'd3;
  localparam logic [2:0] EV_FULL    = 3'd4;

  localparam logic [31:0] IDLE_HORIZON = 32'd10000000;
  localparam logic [31:0] STALE_LIMIT  = 32'd1000;

  localparam logic CFG_TPU   = 1'b0;
  localparam logic CFG_DELAY = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now;
    logic [14:0] target_id;
    logic [15:0] sleep_units;
    logic [15:0] run_units;
    logic        target_exists;
  } item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [14:0] event_id;
    logic [31:0] wake_time;
    logic        last;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item, init next_wake
    logic scan;       // evaluate entry at scan index
    logic scan_inc;   // advance scan index
    logic commit;     // apply set operation
    logic emit_wake;  // load wake report into output register
    logic emit_set;   // load set's pre-wake result
    logic out_take;   // output register consumed
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic out_full;
    logic has_pre;
  } stat_t;
endpackage
`default_nettype wire

FILE: rtl/core/duty_cycle_suspend_scheduler_unit.sv
// Duty-cycle suspend scheduler.
// Input stream s_axis: tdata carries op, now, target_id, sleep_units,
// run_units and target_exists. Output stream m_axis: tdata carries
// event_res, event_id and wake_time; tlast marks an item's final result.
// Config: cfg_we with cfg_index 0 (ticks_per_unit) or 1 (start_delay);
// the user must write config only while idle; the block does not enforce this.
// Tick, set and exit items walk all ENTRIES table slots, one per cycle
// while no result waits in the output register. A tick gives a resume,
// suspend or drop result per due or exited entry, then a wake report;
// a set commits after the walk, may give a resume or table-full result
// and then a wake report; an exit gives no result, and an unused op is
// taken and dropped. The walk stalls while a result waits in the output
// register, so a stalled receiver stalls the walk, and after a tick or
// set no new item is taken until the wake report is delivered.
// Reset clears the table, next wake time and config to defaults.
`default_nettype none
module duty_cycle_suspend_scheduler_unit #(
  parameter int ENTRIES = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // op[1:0], now[33:2], target_id[48:34], sleep_units[64:49],
  // run_units[80:65], target_exists[81], zero pad to 88
  input  wire logic [87:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // event_res[2:0], event_id[17:3], wake_time[49:18], zero pad to 56
  output logic [55:0]       m_axis_tdata,
  output logic              m_axis_tlast,
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);
  import dcss_pkg::*;
  item_t   it;
  result_t r;
  cmd_t    cmd;
  stat_t   stat;

  assign it.op            = s_axis_tdata[1:0];
  assign it.now           = s_axis_tdata[33:2];
  assign it.target_id     = s_axis_tdata[48:34];
  assign it.sleep_units   = s_axis_tdata[64:49];
  assign it.run_units     = s_axis_tdata[80:65];
  assign it.target_exists = s_axis_tdata[81];

  dcss_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_op(it.op), .stat(stat), .cmd(cmd)
  );

  dcss_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .item_in(it),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .res_out(r), .res_valid(m_axis_tvalid), .res_ready(m_axis_tready)
  );

  assign m_axis_tdata = {6'd0, r.wake_time, r.event_id, r.event_res};
  assign m_axis_tlast = r.last;
endmodule
`default_nettype wire

FILE: rtl/core/dcss_datapath.sv
`default_nettype none
module dcss_datapath #(
  parameter int ENTRIES = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire dcss_pkg::cmd_t    cmd,
  output dcss_pkg::stat_t        stat,
  input  wire dcss_pkg::item_t   item_in,
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_idx,
  input  wire logic [15:0]      cfg_data,
  output dcss_pkg::result_t      res_out,
  output logic                  res_valid,
  input  wire logic             res_ready
);
  import dcss_pkg::*;
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [10:0] tpu;
  logic [15:0] start_delay;
  item_t       it;
  logic [31:0] next_wake;
  logic [CW-1:0] idx;

  logic [ENTRIES-1:0] used;
  logic [14:0] s_target [ENTRIES];
  logic [31:0] s_sleep  [ENTRIES];
  logic [31:0] s_run    [ENTRIES];
  logic        s_stop   [ENTRIES];
  logic [31:0] s_exp    [ENTRIES];
  logic        s_gone   [ENTRIES];

  // set/exit lookup state gathered during scan
  logic          found;
  logic [IW-1:0] found_idx;
  logic          free_ok;
  logic [IW-1:0] free_idx;
  logic [31:0]   sl_len, rn_len;
  logic          pre_valid;
  result_t       pre;

  logic [IW-1:0] ci;
  logic          hit, due;
  logic [31:0]   e_new;
  assign ci  = idx[IW-1:0];
  assign hit = used[ci] && (s_target[ci] == it.target_id);
  assign due = s_exp[ci] <= it.now;
  assign e_new = s_stop[ci] ? it.now + s_run[ci] : it.now + s_sleep[ci];

  assign stat.scan_done = (idx == CW'(ENTRIES - 1));
  assign stat.out_full  = res_valid;
  assign stat.has_pre   = pre_valid;

  logic is_del;
  assign is_del = (it.sleep_units == '0) || (it.run_units == '0);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tpu <= 11'd10;
      start_delay <= 16'd10;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_TPU) tpu <= cfg_data[10:0];
      else start_delay <= cfg_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (cmd.scan && it.op == OP_TICK && used[ci] && (s_gone[ci] || due)) begin
      res_valid <= 1'b1;
      res_out <= '{event_res: s_gone[ci] ? EV_DROP : (s_stop[ci] ? EV_RESUME : EV_SUSPEND),
                   event_id: s_target[ci], wake_time: 32'd0, last: 1'b0};
    end else if (cmd.emit_set) begin
      res_valid <= 1'b1;
      res_out <= pre;
    end else if (cmd.emit_wake) begin
      res_valid <= 1'b1;
      res_out <= '{event_res: EV_WAKE, event_id: 15'd0, wake_time: next_wake, last: 1'b1};
    end else if (cmd.out_take && res_ready) res_valid <= 1'b0;
  end

  // item capture, scan and table update
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      next_wake <= '0;
      idx <= '0;
      pre_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        it <= item_in;
        idx <= '0;
        found <= 1'b0;
        free_ok <= 1'b0;
        pre_valid <= 1'b0;
        sl_len <= {16'd0, item_in.sleep_units} * {21'd0, tpu};
        rn_len <= {16'd0, item_in.run_units} * {21'd0, tpu};
        if (item_in.op == OP_TICK) next_wake <= item_in.now + IDLE_HORIZON;
        else if (item_in.op == OP_SET &&
                 (next_wake < item_in.now || next_wake - item_in.now > STALE_LIMIT))
          next_wake <= item_in.now + 32'(start_delay);
      end
      if (cmd.scan) begin
        if (it.op == OP_TICK) begin
          if (used[ci]) begin
            if (s_gone[ci]) used[ci] <= 1'b0;
            else if (due) begin
              s_stop[ci] <= !s_stop[ci];
              s_exp[ci] <= e_new;
              if (next_wake > e_new) next_wake <= e_new;
            end else if (next_wake > s_exp[ci]) next_wake <= s_exp[ci];
          end
        end else begin
          if (hit && !found) begin
            found <= 1'b1;
            found_idx <= ci;
            if (it.op == OP_EXIT) s_gone[ci] <= 1'b1;
          end
          if (!used[ci] && !free_ok) begin
            free_ok <= 1'b1;
            free_idx <= ci;
          end
        end
      end
      if (cmd.scan_inc) idx <= idx + 1'b1;
      if (cmd.commit) begin
        if (is_del) begin
          if (found) begin
            used[found_idx] <= 1'b0;
            if (s_stop[found_idx] && it.target_exists) begin
              pre_valid <= 1'b1;
              pre <= '{event_res: EV_RESUME, event_id: it.target_id, wake_time: 32'd0,
                       last: 1'b0};
            end
          end
        end else if (found) begin
          s_sleep[found_idx] <= sl_len;
          s_run[found_idx] <= rn_len;
          s_exp[found_idx] <= next_wake;
        end else if (it.target_exists) begin
          if (free_ok) begin
            used[free_idx] <= 1'b1;
            s_target[free_idx] <= it.target_id;
            s_stop[free_idx] <= 1'b0;
            s_gone[free_idx] <= 1'b0;
            s_sleep[free_idx] <= sl_len;
            s_run[free_idx] <= rn_len;
            s_exp[free_idx] <= next_wake;
          end else begin
            pre_valid <= 1'b1;
            pre <= '{event_res: EV_FULL, event_id: it.target_id, wake_time: 32'd0,
                     last: 1'b0};
          end
        end
      end
      if (cmd.emit_set) pre_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/dcss_ctrl.sv
`default_nettype none
module dcss_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     in_op,
  input  wire dcss_pkg::stat_t stat,
  output dcss_pkg::cmd_t       cmd
);
  import dcss_pkg::*;
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_COMMIT = 6'b000100,
    S_PRE    = 6'b001000,
    S_WAKE   = 6'b010000,
    S_DRAIN  = 6'b100000
  } state_t;
  state_t state, state_next;
  logic [1:0] op;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
    if (in_valid && in_ready) op <= in_op;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.out_take = 1'b1;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = (in_op == OP_TICK || in_op == OP_SET || in_op == OP_EXIT) ?
                       S_SCAN : S_IDLE;
        end
      end
      S_SCAN: begin
        // wait while a tick's event still sits in the output register
        if (!stat.out_full) begin
          cmd.scan = 1'b1;
          if (stat.scan_done) begin
            state_next = (op == OP_TICK) ? S_WAKE : (op == OP_SET) ? S_COMMIT : S_IDLE;
          end else cmd.scan_inc = 1'b1;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_PRE;
      end
      S_PRE: begin
        if (!stat.out_full) begin
          if (stat.has_pre) cmd.emit_set = 1'b1;
          else state_next = S_WAKE;
        end
      end
      S_WAKE: begin
        if (!stat.out_full) begin
          cmd.emit_wake = 1'b1;
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.out_full) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/core/dcss_checker.sv
`default_nettype none
`include "duty_cycle_suspend_scheduler_unit_macros.svh"
module dcss_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [55:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);
  import dcss_pkg::*;
  // no new item while a result is pending
  `DCSS_ASSERT_IMP(a_no_overlap, clk, rst, m_axis_tvalid, !s_axis_tready)
  // final result is always a wake report
  `DCSS_ASSERT_IMP(a_last_wake, clk, rst, m_axis_tvalid && m_axis_tlast,
    m_axis_tdata[2:0] == EV_WAKE)
  // wake report is always final
  `DCSS_ASSERT_IMP(a_wake_last, clk, rst, m_axis_tvalid && m_axis_tdata[2:0] == EV_WAKE,
    m_axis_tlast)
  // an accepted item is followed by no output valid next cycle
  `DCSS_ASSERT_NXT(a_busy, clk, rst, s_axis_tvalid && s_axis_tready, !m_axis_tvalid)
endmodule
bind duty_cycle_suspend_scheduler_unit dcss_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
